FILE: rtl/lfu_cache_lru_tiebreak_top_macros.svh
// Assertion macros for the LFU cache checker.
// Uses the clk and rst_n names of the module that expands them.
`ifndef LFU_CACHE_LRU_TIEBREAK_TOP_MACROS_SVH
`define LFU_CACHE_LRU_TIEBREAK_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define LFU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfu cache check failed");

// Consequent must hold in the cycle after the antecedent
`define LFU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfu cache check failed");

`endif

FILE: rtl/lfu_pkg.sv
// Shared types and constants for the LFU cache with LRU tie-break.
// No dependencies; used by every module of the block.
package lfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int CAP_W      = 5;
  localparam int CAP_RESET  = 16;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } out_t;

  // One cache slot as held in the entry memory
  typedef struct packed {
    logic [31:0]           key;
    logic [31:0]           value;
    logic [COUNT_BITS-1:0] count;
    logic [31:0]           stamp;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic             vld;
    logic             slot_vld;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } rd_rsp_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           entry;
  } wr_req_t;

  // Outcome of one pass over the slots
  typedef struct packed {
    logic                  match;
    logic [IDX_W-1:0]      match_idx;
    logic [31:0]           match_value;
    logic [COUNT_BITS-1:0] match_count;
    logic                  free;
    logic [IDX_W-1:0]      free_idx;
    logic                  victim;
    logic [IDX_W-1:0]      victim_idx;
    logic [31:0]           victim_key;
    logic [CNT_W-1:0]      used;
  } scan_t;

endpackage

FILE: rtl/lfu_store.sv
// Slot storage: entry memory with registered read, valid bits in flops.
// Depends on lfu_pkg.
module lfu_store (
  input  logic             clk,
  input  logic             rst_n,
  input  lfu_pkg::rd_req_t rd_req,
  output lfu_pkg::rd_rsp_t rd_rsp,
  input  lfu_pkg::wr_req_t wr_req
);
  import lfu_pkg::*;

  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic               rsp_vld_r;
  logic               rsp_slot_vld_r;
  logic [IDX_W-1:0]   rsp_idx_r;
  entry_t             rsp_entry_r;

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_req.entry;
    end
    if (rd_req.en) begin
      rsp_entry_r <= mem[rd_req.addr];
      rsp_idx_r   <= rd_req.addr;
    end
  end

  // Valid bits and read beat flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r        <= '0;
      rsp_vld_r      <= 1'b0;
      rsp_slot_vld_r <= 1'b0;
    end else begin
      rsp_vld_r <= rd_req.en;
      if (rd_req.en) begin
        rsp_slot_vld_r <= valid_r[rd_req.addr];
      end
      if (wr_req.en) begin
        valid_r[wr_req.addr] <= 1'b1;
      end
    end
  end

  assign rd_rsp.vld      = rsp_vld_r;
  assign rd_rsp.slot_vld = rsp_slot_vld_r;
  assign rd_rsp.idx      = rsp_idx_r;
  assign rd_rsp.entry    = rsp_entry_r;

endmodule

FILE: rtl/lfu_scan.sv
// Shared compare unit: folds one slot per cycle into match, free, victim and used count.
// Depends on lfu_pkg.
module lfu_scan (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  lfu_pkg::rd_rsp_t rd_rsp,
  input  logic [31:0]      key,
  input  logic [31:0]      now,
  output lfu_pkg::scan_t   res
);
  import lfu_pkg::*;

  scan_t                 res_r, res_nxt;
  logic [COUNT_BITS-1:0] vcount_r, vcount_nxt;
  logic [31:0]           vage_r, vage_nxt;
  logic [31:0]           age;
  logic                  take_victim;

  // Age of the slot under compare and victim ordering
  always_comb begin
    age         = now - rd_rsp.entry.stamp;
    take_victim = !res_r.victim || (rd_rsp.entry.count < vcount_r) ||
                  ((rd_rsp.entry.count == vcount_r) && (age > vage_r));
  end

  // Fold the current beat into the running result
  always_comb begin
    res_nxt    = res_r;
    vcount_nxt = vcount_r;
    vage_nxt   = vage_r;
    if (start) begin
      res_nxt.match  = 1'b0;
      res_nxt.free   = 1'b0;
      res_nxt.victim = 1'b0;
      res_nxt.used   = '0;
    end else if (rd_rsp.vld) begin
      if (!rd_rsp.slot_vld) begin
        if (!res_r.free) begin
          res_nxt.free     = 1'b1;
          res_nxt.free_idx = rd_rsp.idx;
        end
      end else begin
        res_nxt.used = res_r.used + 1'b1;
        if (!res_r.match && (rd_rsp.entry.key == key)) begin
          res_nxt.match       = 1'b1;
          res_nxt.match_idx   = rd_rsp.idx;
          res_nxt.match_value = rd_rsp.entry.value;
          res_nxt.match_count = rd_rsp.entry.count;
        end
        if (take_victim) begin
          res_nxt.victim     = 1'b1;
          res_nxt.victim_idx = rd_rsp.idx;
          res_nxt.victim_key = rd_rsp.entry.key;
          vcount_nxt         = rd_rsp.entry.count;
          vage_nxt           = age;
        end
      end
    end
  end

  // Flags under reset, data fields free running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.match  <= 1'b0;
      res_r.free   <= 1'b0;
      res_r.victim <= 1'b0;
      res_r.used   <= '0;
    end else begin
      res_r.match  <= res_nxt.match;
      res_r.free   <= res_nxt.free;
      res_r.victim <= res_nxt.victim;
      res_r.used   <= res_nxt.used;
    end
    res_r.match_idx   <= res_nxt.match_idx;
    res_r.match_value <= res_nxt.match_value;
    res_r.match_count <= res_nxt.match_count;
    res_r.free_idx    <= res_nxt.free_idx;
    res_r.victim_idx  <= res_nxt.victim_idx;
    res_r.victim_key  <= res_nxt.victim_key;
    vcount_r          <= vcount_nxt;
    vage_r            <= vage_nxt;
  end

  assign res = res_r;

endmodule

FILE: rtl/lfu_cache_lru_tiebreak_top.sv
// Top level of the LFU cache with LRU tie-break: sequencer and ports.
// Depends on lfu_pkg, lfu_store and lfu_scan.

// Fully associative key/value cache, ENTRIES slots (16), evicting the least
// frequently used entry and, among equal counts, the least recently used one.
// Every item (get or put) gives exactly one result beat. After an item is
// accepted, one pass reads every slot through the single read port of the
// entry memory and folds it into the shared compare unit; the write state
// then waits for a free output register, writes the slot back on a hit or a
// put and loads the output register. in_ready is high only while the block
// is idle; a finished result may wait in the output register while the next
// item is taken. The capacity register is written through cfg_* at any time
// the block is idle; values 0 and above ENTRIES act as 1 and ENTRIES.
module lfu_cache_lru_tiebreak_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  lfu_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lfu_pkg::out_t              out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lfu_pkg::CAP_W-1:0]  cfg_data
);
  import lfu_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CAP_W-1:0] cap_r;
  logic [31:0]      clock_r;
  in_t              item_r;
  logic             out_valid_r;
  out_t             out_r, out_nxt;
  logic             in_fire, out_load, start;
  logic [CNT_W-1:0] eff_cap;
  rd_req_t          rd_req;
  rd_rsp_t          rd_rsp;
  wr_req_t          wr_req;
  scan_t            scan;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign start     = in_fire;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  lfu_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_req (rd_req),
    .rd_rsp (rd_rsp),
    .wr_req (wr_req)
  );

  lfu_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .rd_rsp (rd_rsp),
    .key    (item_r.key),
    .now    (clock_r),
    .res    (scan)
  );

  // Capacity clamped to 1..ENTRIES
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap_r) > 32'(ENTRIES)) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_r);
    end
  end

  // Read sweep over the slots
  always_comb begin
    rd_req.en   = (state_r == S_SCAN) && (rd_idx_r != CNT_W'(ENTRIES));
    rd_req.addr = rd_idx_r[IDX_W-1:0];
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    out_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt  = S_SCAN;
          rd_idx_nxt = '0;
        end
      end
      S_SCAN: begin
        if (rd_idx_r != CNT_W'(ENTRIES)) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Slot write-back and result beat
  always_comb begin
    wr_req.en          = 1'b0;
    wr_req.addr        = scan.match_idx;
    wr_req.entry.key   = item_r.key;
    wr_req.entry.value = item_r.value;
    wr_req.entry.count = COUNT_BITS'(1);
    wr_req.entry.stamp = clock_r;
    out_nxt.hit         = 1'b0;
    out_nxt.read_value  = '0;
    out_nxt.evicted     = 1'b0;
    out_nxt.evicted_key = '0;
    if (scan.match) begin
      out_nxt.hit = 1'b1;
      wr_req.en   = out_load;
      if (scan.match_count != '1) begin
        wr_req.entry.count = scan.match_count + 1'b1;
      end else begin
        wr_req.entry.count = scan.match_count;
      end
      if (item_r.mode == MODE_GET) begin
        out_nxt.read_value = scan.match_value;
        wr_req.entry.value = scan.match_value;
      end
    end else if (item_r.mode == MODE_GET) begin
      out_nxt.read_value = '1;
    end else if ((scan.used >= eff_cap) && scan.victim) begin
      out_nxt.evicted     = 1'b1;
      out_nxt.evicted_key = scan.victim_key;
      wr_req.en           = out_load;
      wr_req.addr         = scan.victim_idx;
    end else begin
      wr_req.en   = out_load && scan.free;
      wr_req.addr = scan.free_idx;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_idx_r    <= '0;
      cap_r       <= CAP_W'(CAP_RESET);
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (out_load) begin
        clock_r     <= clock_r + 32'd1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

endmodule

FILE: rtl/lfu_checker.sv
// Port-level checks for the LFU cache top level, bound to it below.
// Depends on lfu_pkg and the assertion macro header.
`include "lfu_cache_lru_tiebreak_top_macros.svh"

module lfu_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input lfu_pkg::out_t out_data
);
  import lfu_pkg::*;

  // A result beat waits until taken
  `LFU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // The block is busy right after taking an item
  `LFU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // An eviction only happens on a miss
  `LFU_ASSERT_NOW(a_evict_on_miss, out_valid && out_data.evicted, !out_data.hit)
  // No eviction means a zero evicted key
  `LFU_ASSERT_NOW(a_evict_key_zero, out_valid && !out_data.evicted,
                  out_data.evicted_key == 32'sd0)

endmodule

bind lfu_cache_lru_tiebreak_top lfu_checker u_lfu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
